// ===== hw/rtl/lbc_pkg.sv =====
`default_nettype none
package lbc_pkg;

	localparam int HW_LAYERS      = 5;
	localparam int NUM_LAYERS_DEF = 5;
	localparam int NUM_CH         = 3;
	localparam int CH_W           = 8;
	localparam int PIX_W          = NUM_CH * CH_W;
	localparam int OP_W           = 7;
	localparam int MODE_W         = 2;
	localparam int ADDR_W         = 5;
	localparam int IDX_W          = ADDR_W - 2;
	localparam int PROD_W         = OP_W + CH_W;
	localparam int X_W            = PROD_W + CH_W;
	localparam int RCP_W          = 24;
	localparam int Q_W            = X_W + RCP_W;
	localparam int DIV_SHIFT      = 30;

	localparam logic [RCP_W-1:0] DIV_RCP = 24'd10737419;

	localparam logic [OP_W-1:0] OPACITY_MAX = 7'd100;

	localparam logic [MODE_W-1:0] MODE_NORMAL   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MULTIPLY = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DARKEN   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_LIGHTEN  = 2'd3;

	localparam logic [IDX_W-1:0] REG_ENABLE        = 3'd0;
	localparam logic [IDX_W-1:0] REG_MODES         = 3'd1;
	localparam logic [IDX_W-1:0] REG_OPACITY0      = 3'd2;
	localparam logic [IDX_W-1:0] REG_OPACITY_LAST  = 3'd6;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		pix_t                  acc;
		pix_t [HW_LAYERS-1:0]  layer;
	} lbc_item_t;

	typedef struct packed {
		logic              enable;
		logic [MODE_W-1:0] mode;
		logic [OP_W-1:0]   opacity;
	} lbc_layer_cfg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lbc_cfg_regs.sv =====
`default_nettype none
module lbc_cfg_regs import lbc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [ADDR_W-1:0]  paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	output lbc_layer_cfg_t [HW_LAYERS-1:0] cfg
);

	logic [HW_LAYERS-1:0]          enable_q;
	logic [MODE_W*HW_LAYERS-1:0]   modes_q;
	logic [OP_W-1:0]               opacity_q [HW_LAYERS];
	logic [IDX_W-1:0]              idx;
	logic [IDX_W-1:0]              op_idx;
	logic                          wr_en;

	assign idx    = paddr[ADDR_W-1:2];
	assign op_idx = IDX_W'(idx - REG_OPACITY0);
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= HW_LAYERS'(1);
			modes_q  <= {HW_LAYERS{MODE_NORMAL}};
			for (int n = 0; n < HW_LAYERS; n++) begin
				opacity_q[n] <= OPACITY_MAX;
			end
		end else if (wr_en) begin
			case (idx) inside
				REG_ENABLE: enable_q <= pwdata[HW_LAYERS-1:0];
				REG_MODES: modes_q <= pwdata[MODE_W*HW_LAYERS-1:0];
				[REG_OPACITY0:REG_OPACITY_LAST]: opacity_q[op_idx] <= pwdata[OP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx) inside
			REG_ENABLE: prdata = 32'(enable_q);
			REG_MODES: prdata = 32'(modes_q);
			[REG_OPACITY0:REG_OPACITY_LAST]: prdata = 32'(opacity_q[op_idx]);
			default: prdata = 32'd0;
		endcase
	end

	always_comb begin
		for (int n = 0; n < HW_LAYERS; n++) begin
			cfg[n].enable  = enable_q[n];
			cfg[n].mode    = modes_q[MODE_W*n +: MODE_W];
			cfg[n].opacity = (opacity_q[n] > OPACITY_MAX) ? OPACITY_MAX : opacity_q[n];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/lbc_blend_stage.sv =====
`default_nettype none
module lbc_blend_stage import lbc_pkg::*; #(
	parameter int LAYER = 0
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire lbc_layer_cfg_t cfg,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire lbc_item_t      in_item,
	output logic                out_valid,
	input  wire logic           out_ready,
	output lbc_item_t           out_item
);

	logic      v_s1, v_s2, v_s3;
	logic      en_s1, en_s2, en_s3;
	lbc_item_t item_s1, item_s2, item_s3;
	logic [OP_W-1:0] op_inv;

	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign out_valid = v_s3;
	assign op_inv   = OPACITY_MAX - cfg.opacity;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) item_s1 <= in_item;
		if (en_s2) item_s2 <= item_s1;
	end

	pix_t acc_next;

	for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
		logic [CH_W-1:0]   p, r, c, r_s1, r_s2, res;
		logic [PROD_W-1:0] prod_a_s1, prod_b_s1;
		logic [X_W-1:0]    x, x_s2;
		logic [Q_W-1:0]    q;

		assign p    = in_item.layer[LAYER][ch*CH_W +: CH_W];
		assign r    = in_item.acc[ch*CH_W +: CH_W];
		assign r_s1 = item_s1.acc[ch*CH_W +: CH_W];
		assign r_s2 = item_s2.acc[ch*CH_W +: CH_W];

		always_comb begin
			case (cfg.mode)
				MODE_DARKEN: c = (r < p) ? r : p;
				MODE_LIGHTEN: c = (r > p) ? r : p;
				default: c = p;
			endcase
		end

		always_ff @(posedge clk) begin
			if (en_s1) begin
				prod_a_s1 <= PROD_W'(cfg.opacity) * PROD_W'(c);
				prod_b_s1 <= PROD_W'(op_inv) * PROD_W'(r);
			end
		end

		always_comb begin
			if (cfg.mode == MODE_MULTIPLY) begin
				x = X_W'(prod_a_s1) * X_W'(r_s1);
			end else begin
				x = X_W'(prod_a_s1) + X_W'(prod_b_s1);
			end
		end

		always_ff @(posedge clk) begin
			if (en_s2) x_s2 <= x;
		end

		assign q = Q_W'(x_s2) * Q_W'(DIV_RCP);

		always_comb begin
			if (!cfg.enable) begin
				res = r_s2;
			end else if (cfg.mode == MODE_MULTIPLY) begin
				res = q[DIV_SHIFT+CH_W +: CH_W];
			end else begin
				res = q[DIV_SHIFT +: CH_W];
			end
		end

		assign acc_next[ch*CH_W +: CH_W] = res;
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			item_s3.layer <= item_s2.layer;
			item_s3.acc   <= acc_next;
		end
	end

	assign out_item = item_s3;

endmodule
`default_nettype wire

// ===== hw/rtl/layer_blend_compositor.sv =====
// Layer blend compositor.
// Each input beat on s_axis carries one pixel position: the background pixel
// and five layer pixels, each 24-bit RGB. The enabled layers are blended in
// ascending index order over the background, each with its own mode (normal,
// multiply, darken, lighten) and opacity in percent. One output beat on m_axis
// carries the composited pixel.
// Every composited layer takes a three-stage slice of the pipeline: products
// of opacity and channel, the sum or the second product, and the division by
// one hundred through a reciprocal multiplier. One beat is accepted per cycle
// unless a stall on m_axis has backed up the pipeline to the input.
// A stall on m_axis holds the finished pixel in the last register while
// empty stages further up keep taking beats, so nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults: layer zero
// enabled, all modes normal, all opacities one hundred.
// Registers sit on the APB port at byte addresses 0 (enable), 4 (modes) and
// 8 to 24 (opacity of layers zero to four). Write them only while idle.
`default_nettype none
module layer_blend_compositor import lbc_pkg::*; #(
	parameter int NUM_LAYERS = NUM_LAYERS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// background_rgb, layer0_rgb .. layer4_rgb, from the lowest bit up
	input  wire logic [PIX_W*(HW_LAYERS+1)-1:0] s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// blended_rgb
	output logic [PIX_W-1:0]           m_axis_tdata,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [ADDR_W-1:0]     paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready
);

	localparam int ACTIVE = (NUM_LAYERS < HW_LAYERS) ? NUM_LAYERS : HW_LAYERS;

	lbc_layer_cfg_t [HW_LAYERS-1:0] cfg;
	lbc_item_t chain_item  [ACTIVE+1];
	logic      chain_valid [ACTIVE+1];
	logic      chain_ready [ACTIVE+1];

	lbc_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	always_comb begin
		chain_item[0].acc = s_axis_tdata[PIX_W-1:0];
		for (int k = 0; k < HW_LAYERS; k++) begin
			chain_item[0].layer[k] = s_axis_tdata[PIX_W*(k+1) +: PIX_W];
		end
	end

	assign chain_valid[0] = s_axis_tvalid;
	assign s_axis_tready  = chain_ready[0];

	for (genvar g = 0; g < ACTIVE; g++) begin : g_layer
		lbc_blend_stage #(
			.LAYER (g)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg       (cfg[g]),
			.in_valid  (chain_valid[g]),
			.in_ready  (chain_ready[g]),
			.in_item   (chain_item[g]),
			.out_valid (chain_valid[g+1]),
			.out_ready (chain_ready[g+1]),
			.out_item  (chain_item[g+1])
		);
	end

	assign m_axis_tvalid       = chain_valid[ACTIVE];
	assign chain_ready[ACTIVE] = m_axis_tready;
	assign m_axis_tdata        = chain_item[ACTIVE].acc;

endmodule
`default_nettype wire

// ===== hw/rtl/lbc_checker.sv =====
`default_nettype none
module lbc_checker import lbc_pkg::*; (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_axis_tready,
	input wire logic                           m_axis_tvalid,
	input wire logic                           m_axis_tready,
	input wire logic [PIX_W-1:0]               m_axis_tdata,
	input wire logic                           psel,
	input wire logic                           penable,
	input wire logic                           pwrite,
	input wire logic [ADDR_W-1:0]              paddr,
	input wire logic [31:0]                    pwdata,
	input wire logic [31:0]                    prdata,
	input wire logic                           pready
);

	// A stalled output beat keeps its pixel.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");

	// With the last stage empty no stage can be stalled, so input must be ready.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input not ready while output register is empty");

	// A write to the enable register reads back on the next cycle.
	a_enable_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_ENABLE
		|=> paddr[ADDR_W-1:2] != REG_ENABLE
			|| prdata == 32'($past(pwdata[HW_LAYERS-1:0])))
		else $error("enable register readback mismatch");

endmodule

bind layer_blend_compositor lbc_checker u_lbc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.psel          (psel),
	.penable       (penable),
	.pwrite        (pwrite),
	.paddr         (paddr),
	.pwdata        (pwdata),
	.prdata        (prdata),
	.pready        (pready)
);
`default_nettype wire

// ===== test/lbc_checker.sv =====
`timescale 1ns / 1ps
module lbc_scoreboard import lbc_pkg::*; (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	input  wire logic                           s_axis_tready,
	// background_rgb, layer0_rgb .. layer4_rgb, from the lowest bit up
	input  wire logic [PIX_W*(HW_LAYERS+1)-1:0] s_axis_tdata,
	input  wire logic                           m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// blended_rgb
	input  wire logic [PIX_W-1:0]               m_axis_tdata,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [ADDR_W-1:0]              paddr,
	input  wire logic [31:0]                    pwdata,
	input  wire logic                           pready,
	output int                                  outstanding,
	output int                                  fail_count
);

	localparam int MUL_SHIFT = 8;

	logic [HW_LAYERS-1:0]        en_mask;
	logic [MODE_W*HW_LAYERS-1:0] mode_bits;
	logic [OP_W-1:0]             opac [HW_LAYERS];
	pix_t                        blended_q [$];

	function automatic logic [CH_W-1:0] blend_chan(input logic [MODE_W-1:0] mode,
			input logic [OP_W-1:0] op_raw, input logic [CH_W-1:0] p,
			input logic [CH_W-1:0] r);
		int unsigned op;
		int unsigned c;
		int unsigned v;
		int unsigned pu;
		int unsigned ru;
		int unsigned opmax;
		opmax = 32'(OPACITY_MAX);
		op = 32'(op_raw);
		if (op > opmax)
			op = opmax;
		pu = 32'(p);
		ru = 32'(r);
		c = pu;
		case (mode)
			MODE_MULTIPLY: begin
				v = ((op * pu * ru) / opmax) >> MUL_SHIFT;
				return v[CH_W-1:0];
			end
			MODE_DARKEN:  c = (ru < pu) ? ru : pu;
			MODE_LIGHTEN: c = (ru > pu) ? ru : pu;
			default:      c = pu;
		endcase
		v = (op * c + (opmax - op) * ru) / opmax;
		return v[CH_W-1:0];
	endfunction

	function automatic pix_t composite(input logic [PIX_W*(HW_LAYERS+1)-1:0] beat);
		pix_t acc;
		pix_t res;
		acc = beat[PIX_W-1:0];
		for (int k = 0; k < HW_LAYERS; k++) begin
			if (k < NUM_LAYERS_DEF && en_mask[k]) begin
				for (int ch = 0; ch < NUM_CH; ch++) begin
					res[CH_W*ch +: CH_W] = blend_chan(mode_bits[MODE_W*k +: MODE_W], opac[k],
						beat[PIX_W*(k+1) + CH_W*ch +: CH_W], acc[CH_W*ch +: CH_W]);
				end
				acc = res;
			end
		end
		return acc;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		logic [IDX_W-1:0] widx;
		pix_t             want;
		int               errs;
		if (!arst_n) begin
			en_mask     <= HW_LAYERS'(1);
			mode_bits   <= '0;
			for (int k = 0; k < HW_LAYERS; k++)
				opac[k] <= OPACITY_MAX;
			blended_q.delete();
			outstanding <= 0;
			fail_count  <= 0;
		end else begin
			errs = 0;
			if (psel && penable && pwrite && pready) begin
				widx = paddr[ADDR_W-1:2];
				if (widx == REG_ENABLE)
					en_mask <= pwdata[HW_LAYERS-1:0];
				else if (widx == REG_MODES)
					mode_bits <= pwdata[MODE_W*HW_LAYERS-1:0];
				else if (widx >= REG_OPACITY0 && widx <= REG_OPACITY_LAST)
					opac[widx - REG_OPACITY0] <= pwdata[OP_W-1:0];
			end
			if (s_axis_tvalid && s_axis_tready)
				blended_q = {blended_q, composite(s_axis_tdata)};
			if (m_axis_tvalid && m_axis_tready) begin
				if (blended_q.size() == 0) begin
					$display("%0t: unexpected output beat, actual %06h", $time, m_axis_tdata);
					errs++;
				end else begin
					want = blended_q.pop_front();
					if (m_axis_tdata !== want) begin
						$display("%0t: blended_rgb mismatch, expected %06h, actual %06h",
							$time, want, m_axis_tdata);
						errs++;
					end
				end
			end
			outstanding <= blended_q.size();
			fail_count  <= fail_count + errs;
		end
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import lbc_pkg::*;

	localparam int BEAT_W      = PIX_W * (HW_LAYERS + 1);
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 160;
	localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(REG_OPACITY_LAST + 1);

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [BEAT_W-1:0] s_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [PIX_W-1:0]  m_axis_tdata;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	int                outstanding;
	int                fail_count;
	int                idle_pct;
	int                quiet;
	int                rx_hold;

	layer_blend_compositor dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	lbc_scoreboard u_scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.outstanding  (outstanding),
		.fail_count   (fail_count)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(negedge clk) begin
		if (rx_hold > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold = rx_hold - 1;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			m_axis_tready <= 1'b0;
			rx_hold = $urandom_range(0, 2);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(psel && penable && pwrite && pready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_blend(input logic [HW_LAYERS-1:0] en, input logic [9:0] modes,
			input logic [OP_W-1:0] o0, input logic [OP_W-1:0] o1, input logic [OP_W-1:0] o2,
			input logic [OP_W-1:0] o3, input logic [OP_W-1:0] o4);
		apb_write(REG_ENABLE, 32'(en));
		apb_write(REG_MODES, 32'(modes));
		apb_write(REG_OPACITY0, 32'(o0));
		apb_write(IDX_W'(REG_OPACITY0 + 1), 32'(o1));
		apb_write(IDX_W'(REG_OPACITY0 + 2), 32'(o2));
		apb_write(IDX_W'(REG_OPACITY0 + 3), 32'(o3));
		apb_write(IDX_W'(REG_OPACITY0 + 4), 32'(o4));
	endtask

	task automatic push_pixel(input logic [BEAT_W-1:0] d);
		int gap;
		gap = 0;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
			gap = $urandom_range(1, 3);
		@(negedge clk);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic drain;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	function automatic logic [OP_W-1:0] pick_opacity();
		case ($urandom_range(0, 7))
			0: return 7'd0;
			1: return 7'd1;
			2: return 7'd99;
			3: return OPACITY_MAX;
			4: return 7'd101;
			5: return 7'd127;
			default: return 7'($urandom_range(0, 127));
		endcase
	endfunction

	function automatic logic [CH_W-1:0] pick_chan();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [BEAT_W-1:0] random_beat();
		logic [BEAT_W-1:0] b;
		for (int i = 0; i < NUM_CH * (HW_LAYERS + 1); i++)
			b[CH_W*i +: CH_W] = pick_chan();
		return b;
	endfunction

	function automatic logic [BEAT_W-1:0] directed_beat(input int n);
		case (n)
			0: return '0;
			1: return '1;
			2: return {24'h80FF00, 24'hFF0080, 24'h80FF00, 24'hFF0080, 24'h80FF00, 24'h00FF80};
			default: return {{HW_LAYERS{24'h000000}}, 24'hFFFFFF};
		endcase
	endfunction

	task automatic directed_set;
		for (int n = 0; n < 4; n++)
			push_pixel(directed_beat(n));
		drain();
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		idle_pct      = 0;
		quiet         = 0;
		rx_hold       = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed_set();
		set_blend('1, {HW_LAYERS{MODE_MULTIPLY}}, OPACITY_MAX, OPACITY_MAX, OPACITY_MAX,
			OPACITY_MAX, OPACITY_MAX);
		directed_set();
		set_blend('1, {HW_LAYERS{MODE_DARKEN}}, 7'd50, 7'd1, 7'd99, OPACITY_MAX, 7'd0);
		directed_set();
		set_blend('1, {HW_LAYERS{MODE_LIGHTEN}}, 7'd127, 7'd101, OPACITY_MAX, 7'd80, 7'd20);
		directed_set();
		set_blend('0, {MODE_LIGHTEN, MODE_DARKEN, MODE_MULTIPLY, MODE_NORMAL, MODE_LIGHTEN},
			7'd60, 7'd60, 7'd60, 7'd60, 7'd60);
		apb_write(REG_UNUSED, 32'hFFFF_FFFF);
		directed_set();
		set_blend('1, {MODE_LIGHTEN, MODE_DARKEN, MODE_MULTIPLY, MODE_NORMAL, MODE_NORMAL},
			7'd0, OPACITY_MAX, 7'd37, 7'd127, OPACITY_MAX);
		directed_set();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0)
				set_blend('1, 10'($urandom), OPACITY_MAX, OPACITY_MAX, OPACITY_MAX,
					OPACITY_MAX, OPACITY_MAX);
			else if (ph == 1)
				set_blend('1, 10'($urandom), 7'd0, 7'd0, 7'd0, 7'd0, 7'd0);
			else
				set_blend(5'($urandom), 10'($urandom), pick_opacity(), pick_opacity(),
					pick_opacity(), pick_opacity(), pick_opacity());
			if (ph == PHASES - 1 || ph % 3 == 0)
				idle_pct = 0;
			else
				idle_pct = (ph % 3 == 1) ? 15 : 35;
			for (int i = 0; i < PHASE_ITEMS; i++)
				push_pixel(random_beat());
			drain();
		end

		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
